@@ rtl/core/s2cd_pkg.sv @@
// Package for the seconds-to-calendar-date converter.
// Holds the calendar constants and the month-offset table shared by the RTL.
// No dependencies.
package s2cd_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerWeek = 7;
  localparam int unsigned DayBias     = 1524;
  // Year term: C = (100*B - YearOfs) / YearDiv
  localparam int unsigned YearScale   = 100;
  localparam int unsigned YearOfs     = 12210;
  localparam int unsigned YearDiv     = 36525;
  // Month term: E = (MonScale*(B - D)) / MonDiv
  localparam int unsigned MonScale    = 10000;
  localparam int unsigned MonDiv      = 306001;
  localparam int unsigned QuadDays    = 1461;
  // Day-of-year offsets for the two halves of the shifted year.
  localparam logic [8:0]  YdayOfsEarly = 9'd429;
  localparam logic [8:0]  YdayOfsLate  = 9'd64;
  localparam logic [3:0]  MonOfsEarly  = 4'd14;
  localparam logic [3:0]  MonOfsLate   = 4'd2;
  localparam logic [3:0]  LastLateE    = 4'd13;
  localparam logic [2:0]  WeekdayBias  = 3'd5;

  typedef logic [3:0] mon_term_t;
  typedef logic [8:0] day_cnt_t;

  // Days before month term E: floor(30.6001 * E).
  function automatic day_cnt_t month_days(input mon_term_t e);
    day_cnt_t f;
    case (e)
      4'd0:    f = 9'd0;
      4'd1:    f = 9'd30;
      4'd2:    f = 9'd61;
      4'd3:    f = 9'd91;
      4'd4:    f = 9'd122;
      4'd5:    f = 9'd153;
      4'd6:    f = 9'd183;
      4'd7:    f = 9'd214;
      4'd8:    f = 9'd244;
      4'd9:    f = 9'd275;
      4'd10:   f = 9'd306;
      4'd11:   f = 9'd336;
      4'd12:   f = 9'd367;
      4'd13:   f = 9'd397;
      4'd14:   f = 9'd428;
      default: f = 9'd459;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/seconds_to_calendar_date_top.sv @@
// Seconds since 1 Jan 1904 to calendar fields, fully pipelined.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// The depth is set by one chain of three three-stage constant dividers (days, then year,
// then month) plus four single-register levels around them. Reset clears only the valid
// bits; results in flight are dropped.
// Depends on s2cd_pkg and s2cd_cdiv.
module seconds_to_calendar_date_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] seconds_since_1904,
  output logic        done,
  output logic [7:0]  year_since_1900,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [8:0]  day_of_year,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute,
  output logic [2:0]  weekday
);

  import s2cd_pkg::*;

  // Valid bit for each pipeline level; bit k marks level k+1.
  logic [12:0] vld;

  // Level 3: whole days and second of the day.
  logic [15:0] a3;
  logic [16:0] rem3;
  // Level 4: shifted day count, year-term dividend, weekday dividend.
  logic [15:0] b4;
  logic [15:0] b_comb;
  logic [22:0] xc4;
  logic [15:0] xw4;
  logic [16:0] rem4;
  // Level 7 outputs of the parallel dividers.
  logic [7:0]  c7;
  logic [2:0]  wd7;
  logic [4:0]  hour7;
  logic [11:0] rem7;
  // Level 8 and 9: day within the shifted year, month-term dividend.
  logic [18:0] d_full;
  logic [15:0] bd_full;
  logic [8:0]  bd8;
  logic [22:0] y9;
  // Level 10 and 12 divider outputs.
  logic [5:0]  min10;
  logic [5:0]  sec10;
  logic [3:0]  e12;

  // Delay lines that carry finished fields alongside the later stages.
  logic [15:0] b_dly   [3];
  logic [7:0]  c_dly   [5];
  logic [2:0]  wd_dly  [5];
  logic [4:0]  hour_dly[5];
  logic [5:0]  min_dly [2];
  logic [5:0]  sec_dly [2];
  logic [8:0]  bd_dly  [4];

  logic        late_half;
  logic [8:0]  yday_late;

  // Every cycle takes a new item, so the block never reports busy.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[11:0], start & ~busy};
    end
  end

  assign done = vld[12];

  // Split the count into whole days and seconds within the day.
  s2cd_cdiv #(
    .XW(32), .QW(16), .DIV(SecsPerDay), .MUL(49710), .SH(32)
  ) u_day_div (
    .clk (clk),
    .x   (seconds_since_1904),
    .q   (a3),
    .r   (rem3)
  );

  // Level 4: bias the day count and form the dividends of the next dividers.
  assign b_comb = a3 + 16'(DayBias);

  always_ff @(posedge clk) begin
    b4   <= b_comb;
    xc4  <= 23'(b_comb) * 23'(YearScale) - 23'(YearOfs);
    xw4  <= a3 + 16'(WeekdayBias);
    rem4 <= rem3;
  end

  // Year term C.
  s2cd_cdiv #(
    .XW(23), .QW(8), .DIV(YearDiv), .MUL(229), .SH(23)
  ) u_year_div (
    .clk (clk),
    .x   (xc4),
    .q   (c7),
    .r   ()
  );

  // Weekday is the remainder of the biased day count by seven.
  s2cd_cdiv #(
    .XW(16), .QW(13), .DIV(DaysPerWeek), .MUL(9362), .SH(16)
  ) u_week_div (
    .clk (clk),
    .x   (xw4),
    .q   (),
    .r   (wd7)
  );

  // Hour of day and seconds within the hour.
  s2cd_cdiv #(
    .XW(17), .QW(5), .DIV(SecsPerHour), .MUL(36), .SH(17)
  ) u_hour_div (
    .clk (clk),
    .x   (rem4),
    .q   (hour7),
    .r   (rem7)
  );

  // Minute and second.
  s2cd_cdiv #(
    .XW(12), .QW(6), .DIV(SecsPerMin), .MUL(68), .SH(12)
  ) u_min_div (
    .clk (clk),
    .x   (rem7),
    .q   (min10),
    .r   (sec10)
  );

  // D = floor(1461*C / 4); the day within the shifted year is B - D and
  // always fits in nine bits.
  assign d_full  = 19'(c7) * 19'(QuadDays);
  assign bd_full = b_dly[2] - d_full[17:2];

  always_ff @(posedge clk) begin
    bd8 <= bd_full[8:0];
    y9  <= 23'(bd8) * 23'(MonScale);
  end

  // Month term E.
  s2cd_cdiv #(
    .XW(23), .QW(4), .DIV(MonDiv), .MUL(27), .SH(23)
  ) u_mon_div (
    .clk (clk),
    .x   (y9),
    .q   (e12),
    .r   ()
  );

  always_ff @(posedge clk) begin
    b_dly[0] <= b4;
    b_dly[1] <= b_dly[0];
    b_dly[2] <= b_dly[1];
    c_dly[0]    <= c7;
    wd_dly[0]   <= wd7;
    hour_dly[0] <= hour7;
    for (int i = 1; i < 5; i++) begin
      c_dly[i]    <= c_dly[i-1];
      wd_dly[i]   <= wd_dly[i-1];
      hour_dly[i] <= hour_dly[i-1];
    end
    min_dly[0] <= min10;
    sec_dly[0] <= sec10;
    min_dly[1] <= min_dly[0];
    sec_dly[1] <= sec_dly[0];
    bd_dly[0] <= bd8;
    for (int i = 1; i < 4; i++) begin
      bd_dly[i] <= bd_dly[i-1];
    end
  end

  // January and February belong to the following year in the shifted calendar.
  // For March onward a leap year adds the 29th of February to the day of year.
  assign late_half = (e12 > LastLateE);
  assign yday_late = bd_dly[3] - YdayOfsLate + 9'(c_dly[4][1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (late_half) begin
      year_since_1900 <= c_dly[4] + 8'd1;
      month_index     <= e12 - MonOfsEarly;
      day_of_year     <= bd_dly[3] - YdayOfsEarly;
    end else begin
      year_since_1900 <= c_dly[4];
      month_index     <= e12 - MonOfsLate;
      day_of_year     <= yday_late;
    end
    day_of_month     <= 5'(bd_dly[3] - month_days(e12));
    hour_of_day      <= hour_dly[4];
    minute_of_hour   <= min_dly[1];
    second_of_minute <= sec_dly[1];
    weekday          <= wd_dly[4];
  end

  // A result appears only for an item that start brought in.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 13))
    else $error("done without a matching start");

  // Every delivered time of day and weekday is in range.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60 &&
              second_of_minute < 6'd60 && weekday < 3'd7))
    else $error("time field out of range");

  // Every delivered date is a real calendar date.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_index < 4'd12 && day_of_month != 5'd0 && day_of_year < 9'd366))
    else $error("date field out of range");

  // The month term always lands in the March-to-February window.
  a_month_term: assert property (@(posedge clk) disable iff (rst)
    vld[11] |-> (e12 >= 4'd4))
    else $error("month term below March");

endmodule

@@ rtl/core/s2cd_cdiv.sv @@
// Three-stage divider by a constant using a scaled reciprocal and one correction step.
// Stand-alone; used by seconds_to_calendar_date_top.
module s2cd_cdiv #(
  parameter int unsigned XW  = 32,     // dividend width
  parameter int unsigned QW  = 16,     // quotient width
  parameter int unsigned DIV = 86400,  // divisor
  parameter int unsigned MUL = 49710,  // floor(2**SH / DIV)
  parameter int unsigned SH  = 32      // reciprocal scale, dividend must stay below 2**SH
) (
  input  logic                       clk,
  input  logic [XW-1:0]              x,
  output logic [QW-1:0]              q,
  output logic [$clog2(DIV)-1:0]     r
);

  localparam int unsigned MW = $clog2(MUL + 1);
  localparam int unsigned DW = $clog2(DIV + 1);
  localparam int unsigned RW = $clog2(DIV);
  localparam int unsigned PW = (XW > QW + DW) ? XW : QW + DW;

  logic [XW+MW-1:0] prod;
  logic [QW-1:0]    q0;
  logic [XW-1:0]    x1;
  logic [PW-1:0]    p;
  logic [QW-1:0]    q1;
  logic [XW-1:0]    x2;
  logic [PW-1:0]    diff;
  logic             corr;

  // Estimate: at most one below the true quotient.
  assign prod = {{MW{1'b0}}, x} * (XW + MW)'(MUL);

  always_ff @(posedge clk) begin
    q0 <= prod[SH +: QW];
    x1 <= x;
  end

  always_ff @(posedge clk) begin
    p  <= PW'(q0) * PW'(DIV);
    q1 <= q0;
    x2 <= x1;
  end

  // The partial remainder is below twice the divisor.
  assign diff = PW'(x2) - p;
  assign corr = (diff >= PW'(DIV));

  always_ff @(posedge clk) begin
    q <= q1 + QW'(corr);
    r <= corr ? RW'(diff - PW'(DIV)) : RW'(diff);
  end

endmodule
